[rtl/ptc_pkg.sv]
// Package for the peer table with transmit credits.
// Holds the field widths, action and status codes, and the transaction and control structs.
// No dependencies.
package ptc_pkg;

    localparam int MAC_W  = 48;
    localparam int ADDR_W = 16;
    localparam int RSSI_W = 8;
    localparam int LEN_W  = 11;
    localparam int CRED_W = 7;
    localparam int STAT_W = 3;

    localparam logic [1:0] ACT_LEARN = 2'd0;
    localparam logic [1:0] ACT_SEND  = 2'd1;
    localparam logic [1:0] ACT_DONE  = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LONG  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_CREDIT = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STAT_W-1:0] ST_ADDED     = 3'd5;
    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd6;

    localparam logic [ADDR_W-1:0] BCAST_ADDR    = 16'hFFFF;
    localparam logic [RSSI_W-1:0] RSSI_UNKNOWN  = 8'h81;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 11'd1470;

    typedef struct packed {
        logic [1:0]               action;
        logic [MAC_W-1:0]         peer_mac;
        logic signed [RSSI_W-1:0] rssi_in;
        logic [ADDR_W-1:0]        peer_address;
        logic [LEN_W-1:0]         payload_len;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [MAC_W-1:0]         dest_mac;
        logic                     is_broadcast;
        logic signed [RSSI_W-1:0] rssi_out;
        logic [CRED_W-1:0]        credits_left;
    } out_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic hit;
        logic last;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/ptc_ctrl.sv]
// Controller for the peer table: accepts a transaction, sequences the table scan, commits.
// Depends on ptc_pkg.
module ptc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ptc_pkg::dp_stat_t    stat,
    output ptc_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        IDLE,
        READ,
        CMP,
        FINISH
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        state_reg <= stat.need_scan ? READ : FINISH;
                    end
                end
                READ: begin
                    state_reg <= CMP;
                end
                CMP: begin
                    if (stat.hit || stat.last) begin
                        state_reg <= FINISH;
                    end else begin
                        state_reg <= READ;
                    end
                end
                FINISH: begin
                    if (stat.out_free) begin
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == IDLE);
    assign cmd.load   = (state_reg == IDLE) && s_valid;
    assign cmd.rd     = (state_reg == READ);
    assign cmd.step   = (state_reg == CMP);
    assign cmd.commit = (state_reg == FINISH) && stat.out_free;

endmodule

[rtl/ptc_datapath.sv]
// Datapath for the peer table: item and config registers, credit pool, entry store,
// scan compare and result register. Depends on ptc_pkg.
module ptc_datapath #(
    parameter int TABLE_ENTRIES = 8,
    parameter int CREDIT_DEPTH  = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ptc_pkg::in_t                       s_data,
    input  logic                               cfg_wr_en,
    input  logic [ptc_pkg::LEN_W-1:0]          cfg_wr_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ptc_pkg::out_t                      m_data,
    input  ptc_pkg::ctrl_cmd_t                 cmd,
    output ptc_pkg::dp_stat_t                  stat
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [ptc_pkg::CRED_W-1:0] CREDIT_MAX = ptc_pkg::CRED_W'(CREDIT_DEPTH);

    ptc_pkg::in_t                   item_reg;
    logic [ptc_pkg::LEN_W-1:0]      max_len_reg;
    logic [ptc_pkg::CRED_W-1:0]     credits_reg;
    logic [ptc_pkg::CRED_W-1:0]     cred_next;
    logic [TABLE_ENTRIES-1:0]       valid_reg;

    logic [ptc_pkg::MAC_W-1:0]      mac_mem  [TABLE_ENTRIES];
    logic [ptc_pkg::ADDR_W-1:0]     addr_mem [TABLE_ENTRIES];
    logic [ptc_pkg::RSSI_W-1:0]     rssi_mem [TABLE_ENTRIES];

    logic [IDX_W-1:0]               idx_reg;
    logic                           rd_valid_reg;
    logic [ptc_pkg::MAC_W-1:0]      rd_mac_reg;
    logic [ptc_pkg::ADDR_W-1:0]     rd_addr_reg;
    logic [ptc_pkg::RSSI_W-1:0]     rd_rssi_reg;
    logic                           found_reg;
    logic                           free_found_reg;
    logic [IDX_W-1:0]               free_idx_reg;

    ptc_pkg::out_t                  out_reg;
    logic                           out_valid_reg;
    ptc_pkg::out_t                  res;

    logic [ptc_pkg::ADDR_W-1:0]     key;
    logic                           hit;
    logic                           need_scan;
    logic                           wr_en;
    logic                           wr_new;
    logic [IDX_W-1:0]               wr_idx;

    assign key = (item_reg.action == ptc_pkg::ACT_LEARN) ?
                 item_reg.peer_mac[ptc_pkg::ADDR_W-1:0] : item_reg.peer_address;
    assign hit = rd_valid_reg && (rd_addr_reg == key);

    always_comb begin
        need_scan = 1'b1;
        if (s_data.action == ptc_pkg::ACT_SEND) begin
            need_scan = (s_data.payload_len <= max_len_reg) && (credits_reg != '0) &&
                        (s_data.peer_address != ptc_pkg::BCAST_ADDR);
        end else if (s_data.action == ptc_pkg::ACT_DONE) begin
            need_scan = 1'b0;
        end
    end

    assign stat.need_scan = need_scan;
    assign stat.hit       = hit;
    assign stat.last      = (idx_reg == LAST_IDX);
    assign stat.out_free  = !out_valid_reg || m_ready;

    always_comb begin
        res       = '0;
        cred_next = credits_reg;
        wr_en     = 1'b0;
        wr_new    = 1'b0;
        wr_idx    = idx_reg;
        case (item_reg.action)
            ptc_pkg::ACT_LEARN: begin
                if (found_reg) begin
                    res.status = ptc_pkg::ST_UPDATED;
                    wr_en      = 1'b1;
                end else if (free_found_reg) begin
                    res.status = ptc_pkg::ST_ADDED;
                    wr_en      = 1'b1;
                    wr_new     = 1'b1;
                    wr_idx     = free_idx_reg;
                end else begin
                    res.status = ptc_pkg::ST_FULL;
                end
            end
            ptc_pkg::ACT_SEND: begin
                if (item_reg.payload_len > max_len_reg) begin
                    res.status = ptc_pkg::ST_TOO_LONG;
                end else if (credits_reg == '0) begin
                    res.status = ptc_pkg::ST_NO_CREDIT;
                end else if (item_reg.peer_address == ptc_pkg::BCAST_ADDR) begin
                    res.dest_mac     = '1;
                    res.is_broadcast = 1'b1;
                    cred_next        = credits_reg - 1'b1;
                end else if (found_reg) begin
                    res.dest_mac = rd_mac_reg;
                    cred_next    = credits_reg - 1'b1;
                end else begin
                    res.status = ptc_pkg::ST_NOT_FOUND;
                end
            end
            ptc_pkg::ACT_DONE: begin
                if (credits_reg < CREDIT_MAX) begin
                    cred_next = credits_reg + 1'b1;
                end
            end
            ptc_pkg::ACT_QUERY: begin
                if (found_reg) begin
                    res.rssi_out = rd_rssi_reg;
                end else begin
                    res.status   = ptc_pkg::ST_NOT_FOUND;
                    res.rssi_out = ptc_pkg::RSSI_UNKNOWN;
                end
            end
            default: begin
                res.status = ptc_pkg::ST_OK;
            end
        endcase
        res.credits_left = cred_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= ptc_pkg::MAX_LEN_RESET;
            credits_reg    <= CREDIT_MAX;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (cmd.rd) begin
                rd_valid_reg <= valid_reg[idx_reg];
            end
            if (cmd.step) begin
                found_reg <= hit;
                if (!rd_valid_reg && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= idx_reg;
                end
                if (!hit && !stat.last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.commit) begin
                credits_reg   <= cred_next;
                out_valid_reg <= 1'b1;
                if (wr_new) begin
                    valid_reg[wr_idx] <= 1'b1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.rd) begin
            rd_mac_reg  <= mac_mem[idx_reg];
            rd_addr_reg <= addr_mem[idx_reg];
            rd_rssi_reg <= rssi_mem[idx_reg];
        end
        if (cmd.commit) begin
            out_reg <= res;
            if (wr_en) begin
                rssi_mem[wr_idx] <= item_reg.rssi_in;
            end
            if (wr_new) begin
                mac_mem[wr_idx]  <= item_reg.peer_mac;
                addr_mem[wr_idx] <= item_reg.peer_mac[ptc_pkg::ADDR_W-1:0];
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[rtl/peer_table_with_tx_credits.sv]
// Top level of the peer table with transmit credits.
// Depends on ptc_pkg, ptc_ctrl and ptc_datapath.
//
// Usage:
// - Input channel s_valid/s_ready/s_data carries one transaction: learn, send request,
//   send done or RSSI query. Result channel m_valid/m_ready/m_data returns exactly one
//   result transaction per input, in order.
// - cfg_wr_en/cfg_wr_data write the maximum payload length; write only while idle.
// - Flow: a send done, a rejected send or a broadcast send goes from acceptance straight to
//   the commit step. Learn, query and unicast send scan the table one entry at a time
//   (registered read, then compare), stopping at the first match or at the last entry.
//   The controller returns to idle as the result is placed in the output register.
// - One transaction is in work at a time; s_ready is high while the controller is idle,
//   even while a finished result still waits in the output register.
// - A stalled receiver holds the result in the output register and the controller in
//   its commit step until the register frees.
// - Synchronous reset clears all entry valid bits, refills the credit pool to
//   CREDIT_DEPTH and restores the maximum payload length to 1470.
module peer_table_with_tx_credits #(
    parameter int TABLE_ENTRIES = 8,
    parameter int CREDIT_DEPTH  = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ptc_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ptc_pkg::out_t                 m_data,
    input  logic                          cfg_wr_en,
    input  logic [ptc_pkg::LEN_W-1:0]     cfg_wr_data
);

    ptc_pkg::ctrl_cmd_t cmd;
    ptc_pkg::dp_stat_t  stat;

    ptc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CREDIT_DEPTH  (CREDIT_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

[rtl/ptc_checker.sv]
// Port-level checks for the peer table with transmit credits, and their bind.
// Depends on ptc_pkg and peer_table_with_tx_credits.
module ptc_checker #(
    parameter int CREDIT_DEPTH = 8
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input ptc_pkg::out_t                 m_data
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result transaction changed");

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.credits_left <= ptc_pkg::CRED_W'(CREDIT_DEPTH))
        else $error("credit pool above depth");

    a_bcast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_broadcast |->
            m_data.status == ptc_pkg::ST_OK && m_data.dest_mac == '1)
        else $error("broadcast result malformed");

    a_fail_no_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ptc_pkg::ST_OK |->
            m_data.dest_mac == '0 && !m_data.is_broadcast)
        else $error("failed transaction carries a destination");

endmodule

bind peer_table_with_tx_credits ptc_checker #(.CREDIT_DEPTH(CREDIT_DEPTH)) u_ptc_checker (.*);

[dv/peer_table_with_tx_credits_tb.sv]
// Testbench for peer_table_with_tx_credits: directed and random learn, send, send-done and
// query transactions, each result checked against an in-bench model of the table and credits.
// Depends on ptc_pkg and the peer_table_with_tx_credits RTL.
module peer_table_with_tx_credits_tb;

    localparam int TABLE_ENTRIES = 8;
    localparam int CREDIT_DEPTH  = 8;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 500000;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    ptc_pkg::in_t              s_data      = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    ptc_pkg::out_t             m_data;
    logic                      cfg_wr_en   = 1'b0;
    logic [ptc_pkg::LEN_W-1:0] cfg_wr_data = '0;

    logic                              known_valid [TABLE_ENTRIES] = '{default: 1'b0};
    logic [ptc_pkg::MAC_W-1:0]         known_mac   [TABLE_ENTRIES];
    logic [ptc_pkg::ADDR_W-1:0]        known_addr  [TABLE_ENTRIES];
    logic signed [ptc_pkg::RSSI_W-1:0] known_rssi  [TABLE_ENTRIES];
    logic [ptc_pkg::CRED_W-1:0]        credit_pool = ptc_pkg::CRED_W'(CREDIT_DEPTH);
    logic [ptc_pkg::LEN_W-1:0]         len_limit   = ptc_pkg::MAX_LEN_RESET;

    ptc_pkg::out_t pending_results[$];
    ptc_pkg::out_t want;
    int          mismatches     = 0;
    int          items_sent     = 0;
    int          limits_written = 0;
    int          status_seen [8] = '{default: 0};
    int unsigned cycle_count    = 0;
    bit          tx_idle_en     = 1'b1;
    bit          rx_idle_en     = 1'b1;
    bit          long_hold_req  = 1'b0;

    peer_table_with_tx_credits #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .CREDIT_DEPTH (CREDIT_DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int find_peer(input logic [ptc_pkg::ADDR_W-1:0] addr);
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (known_valid[k] && known_addr[k] == addr) begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic ptc_pkg::out_t predict_result(input ptc_pkg::in_t it);
        ptc_pkg::out_t r;
        int            k;
        r = '0;
        case (it.action)
            ptc_pkg::ACT_LEARN: begin
                k = find_peer(it.peer_mac[ptc_pkg::ADDR_W-1:0]);
                if (k >= 0) begin
                    known_rssi[k] = it.rssi_in;
                    r.status = ptc_pkg::ST_UPDATED;
                end else begin
                    r.status = ptc_pkg::ST_FULL;
                    for (int n = 0; n < TABLE_ENTRIES; n++) begin
                        if (!known_valid[n] && r.status == ptc_pkg::ST_FULL) begin
                            known_valid[n] = 1'b1;
                            known_mac[n]   = it.peer_mac;
                            known_addr[n]  = it.peer_mac[ptc_pkg::ADDR_W-1:0];
                            known_rssi[n]  = it.rssi_in;
                            r.status       = ptc_pkg::ST_ADDED;
                        end
                    end
                end
            end
            ptc_pkg::ACT_SEND: begin
                if (it.payload_len > len_limit) begin
                    r.status = ptc_pkg::ST_TOO_LONG;
                end else if (credit_pool == 0) begin
                    r.status = ptc_pkg::ST_NO_CREDIT;
                end else if (it.peer_address == ptc_pkg::BCAST_ADDR) begin
                    credit_pool    = credit_pool - 1'b1;
                    r.dest_mac     = '1;
                    r.is_broadcast = 1'b1;
                end else begin
                    k = find_peer(it.peer_address);
                    if (k >= 0) begin
                        credit_pool = credit_pool - 1'b1;
                        r.dest_mac  = known_mac[k];
                    end else begin
                        r.status = ptc_pkg::ST_NOT_FOUND;
                    end
                end
            end
            ptc_pkg::ACT_DONE: begin
                if (credit_pool < CREDIT_DEPTH) begin
                    credit_pool = credit_pool + 1'b1;
                end
            end
            default: begin
                k = find_peer(it.peer_address);
                if (k >= 0) begin
                    r.rssi_out = known_rssi[k];
                end else begin
                    r.rssi_out = ptc_pkg::RSSI_UNKNOWN;
                    r.status   = ptc_pkg::ST_NOT_FOUND;
                end
            end
        endcase
        r.credits_left = credit_pool;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                len_limit = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with none expected");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        mismatches++;
                    end
                    if (m_data.dest_mac !== want.dest_mac) begin
                        $error("dest_mac: expected %h, got %h", want.dest_mac, m_data.dest_mac);
                        mismatches++;
                    end
                    if (m_data.is_broadcast !== want.is_broadcast) begin
                        $error("is_broadcast: expected %0d, got %0d",
                               want.is_broadcast, m_data.is_broadcast);
                        mismatches++;
                    end
                    if (m_data.rssi_out !== want.rssi_out) begin
                        $error("rssi_out: expected %0d, got %0d", want.rssi_out, m_data.rssi_out);
                        mismatches++;
                    end
                    if (m_data.credits_left !== want.credits_left) begin
                        $error("credits_left: expected %0d, got %0d",
                               want.credits_left, m_data.credits_left);
                        mismatches++;
                    end
                    status_seen[want.status]++;
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(predict_result(s_data));
                items_sent++;
            end
        end
    end

    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input ptc_pkg::in_t it);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_len_limit(input logic [ptc_pkg::LEN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limits_written++;
    endtask

    function automatic ptc_pkg::in_t make_item(input logic [1:0] action,
                                               input logic [ptc_pkg::MAC_W-1:0] mac,
                                               input logic signed [ptc_pkg::RSSI_W-1:0] rssi,
                                               input logic [ptc_pkg::ADDR_W-1:0] addr,
                                               input logic [ptc_pkg::LEN_W-1:0] len);
        ptc_pkg::in_t it;
        it.action       = action;
        it.peer_mac     = mac;
        it.rssi_in      = rssi;
        it.peer_address = addr;
        it.payload_len  = len;
        return it;
    endfunction

    function automatic logic [ptc_pkg::ADDR_W-1:0] pick_address();
        int k;
        k = $urandom_range(0, TABLE_ENTRIES - 1);
        case ($urandom_range(0, 9))
            0, 1:    return ptc_pkg::BCAST_ADDR;
            2, 3, 4: return ptc_pkg::ADDR_W'($urandom);
            default: return known_valid[k] ? known_addr[k] : ptc_pkg::ADDR_W'($urandom);
        endcase
    endfunction

    function automatic ptc_pkg::in_t random_item(input int send_pct);
        ptc_pkg::in_t it;
        it              = '0;
        it.peer_mac     = {16'($urandom), 32'($urandom)};
        it.rssi_in      = ptc_pkg::RSSI_W'($urandom);
        it.peer_address = pick_address();
        case ($urandom_range(0, 2))
            0:       it.payload_len = ptc_pkg::LEN_W'($urandom);
            1:       it.payload_len = ptc_pkg::LEN_W'($urandom_range(0, 64));
            default: it.payload_len = len_limit + ptc_pkg::LEN_W'($urandom_range(0, 2)) - 1'b1;
        endcase
        if ($urandom_range(0, 99) < send_pct) begin
            it.action = ptc_pkg::ACT_SEND;
        end else begin
            case ($urandom_range(0, 2))
                0:       it.action = ptc_pkg::ACT_DONE;
                1:       it.action = ptc_pkg::ACT_QUERY;
                default: it.action = ptc_pkg::ACT_LEARN;
            endcase
        end
        if (it.action == ptc_pkg::ACT_LEARN && $urandom_range(0, 1) == 1) begin
            it.peer_mac[ptc_pkg::ADDR_W-1:0] = pick_address();
        end
        return it;
    endfunction

    task automatic test_empty_table();
        send_item(make_item(ptc_pkg::ACT_QUERY, '0, '0, 16'h0000, '0));
        send_item(make_item(ptc_pkg::ACT_DONE, '0, '0, '0, '0));
    endtask

    task automatic test_learn_and_query();
        send_item(make_item(ptc_pkg::ACT_LEARN, '0, -8'sd128, '0, '0));
        send_item(make_item(ptc_pkg::ACT_LEARN, '1, 8'sd127, '0, '0));
        send_item(make_item(ptc_pkg::ACT_LEARN, 48'hA5A5_5A5A_0000, 8'sd5, '0, '0));
        send_item(make_item(ptc_pkg::ACT_QUERY, '0, '0, 16'h0000, '0));
        send_item(make_item(ptc_pkg::ACT_QUERY, '0, '0, ptc_pkg::BCAST_ADDR, '0));
        for (int k = 1; k <= 6; k++) begin
            send_item(make_item(ptc_pkg::ACT_LEARN,
                                {32'($urandom), ptc_pkg::ADDR_W'(16'h0101 * k)},
                                ptc_pkg::RSSI_W'($urandom), '0, '0));
        end
        send_item(make_item(ptc_pkg::ACT_LEARN, 48'h1234_5678_7777, -8'sd40, '0, '0));
    endtask

    task automatic test_send_rules();
        send_item(make_item(ptc_pkg::ACT_SEND, '0, '0, ptc_pkg::BCAST_ADDR, 11'd1470));
        send_item(make_item(ptc_pkg::ACT_SEND, '0, '0, 16'h0000, 11'd1470));
        send_item(make_item(ptc_pkg::ACT_SEND, '0, '0, 16'h0101, 11'd1471));
        send_item(make_item(ptc_pkg::ACT_SEND, '0, '0, 16'h0202, 11'd2047));
        send_item(make_item(ptc_pkg::ACT_SEND, '0, '0, 16'h0202, 11'd5));
        send_item(make_item(ptc_pkg::ACT_SEND, '0, '0, 16'h4321, 11'd0));
        repeat (6) send_item(make_item(ptc_pkg::ACT_SEND, '0, '0, ptc_pkg::BCAST_ADDR, 11'd0));
    endtask

    task automatic test_random_traffic();
        logic [ptc_pkg::LEN_W-1:0] settings [5];
        settings = '{11'd2047, 11'd0, ptc_pkg::LEN_W'($urandom), 11'd1, ptc_pkg::MAX_LEN_RESET};
        for (int p = 0; p < 5; p++) begin
            wait_for_results();
            write_len_limit(settings[p]);
            tx_idle_en = (p != 2);
            rx_idle_en = (p != 2);
            repeat (330) send_item(random_item(30 + 8 * p));
        end
        wait_for_results();
    endtask

    task automatic test_receiver_holdoff();
        long_hold_req = 1'b1;
        repeat (30) send_item(random_item(40));
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (250) send_item(random_item(45));
        wait_for_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_learn_and_query();
        test_send_rules();
        test_random_traffic();
        test_receiver_holdoff();
        test_back_to_back();
        repeat (40) @(posedge aclk);
        $display("Ran %0d transactions over %0d length limits, incl. table fill, %s",
                 items_sent, limits_written, "credit exhaustion and a long result stall.");
        $display("Statuses: ok %0d, too long %0d, no credit %0d, not found %0d, %s %0d, %s %0d",
                 status_seen[ptc_pkg::ST_OK], status_seen[ptc_pkg::ST_TOO_LONG],
                 status_seen[ptc_pkg::ST_NO_CREDIT], status_seen[ptc_pkg::ST_NOT_FOUND],
                 "full", status_seen[ptc_pkg::ST_FULL], "added/updated",
                 status_seen[ptc_pkg::ST_ADDED] + status_seen[ptc_pkg::ST_UPDATED]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
